// File: src/sanorm_pkg.sv
// Shared constants, codes and interface structs for the slice axis normalizer.
// Used by sanorm_div, sanorm_core and the top level slice_axis_normalizer.
package sanorm_pkg;

  localparam int MAX_RANK = 8;
  localparam int AXIS_W   = $clog2(MAX_RANK);
  localparam int RANK_W   = 4;
  localparam int AXIN_W   = 4;
  localparam int COORD_W  = 32;
  localparam int EXT_W    = 31;
  localparam int WIDE_W   = COORD_W + 2;
  localparam int NUM_W    = COORD_W + 1;
  localparam int DEN_W    = COORD_W;
  localparam int CNT_W    = $clog2(NUM_W + 1);
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_SLICE  = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_AXIS  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_STEP = 2'd2;

  // Register word index carried in paddr[2].
  localparam logic CFG_RANK = 1'b0;
  localparam logic [RANK_W-1:0] RANK_RESET = 4'd1;

  typedef struct packed {
    logic             go;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// File: src/slice_axis_normalizer.sv
// Top level of the slice axis normalizer: APB register for the tensor rank.
// Depends on sanorm_pkg and instantiates sanorm_core (which holds sanorm_div).
//
// This block turns tensor slice requests into per-axis descriptors: first
// source index, step and element count. A load beat stores the extent of one
// axis; a slice beat names an axis (negative counts back from the rank) with
// start, end and step, and gets one descriptor back whose count is a ceiling
// division done by a bit-serial divider; a finish beat returns a full-extent
// descriptor for every axis not sliced since the previous finish, marks the
// final one with last_of_run, and clears the marks. Every load and slice beat
// gives exactly one result beat. The tensor rank lives in the APB register at
// byte address 0 and should only be written while the block is idle; values
// above eight act as eight. Input beats are taken one at a time, and the
// divider produces one quotient bit per cycle. The output register lets
// the block take the next beat while a finished result still waits for
// out_ready. Reading the extent of an axis that was never loaded gives an
// undefined count.
module slice_axis_normalizer (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [sanorm_pkg::APB_AW-1:0]          paddr,
  input  logic [sanorm_pkg::APB_DW-1:0]          pwdata,
  output logic [sanorm_pkg::APB_DW-1:0]          prdata,
  output logic                                   pready,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [sanorm_pkg::OP_W-1:0]            operation,
  input  logic signed [sanorm_pkg::AXIN_W-1:0]   axis_index,
  input  logic signed [sanorm_pkg::COORD_W-1:0]  start_pos,
  input  logic signed [sanorm_pkg::COORD_W-1:0]  end_pos,
  input  logic signed [sanorm_pkg::COORD_W-1:0]  stride,
  input  logic [sanorm_pkg::EXT_W-1:0]           extent_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [sanorm_pkg::AXIS_W-1:0]          out_axis,
  output logic [sanorm_pkg::EXT_W-1:0]           out_start,
  output logic signed [sanorm_pkg::COORD_W-1:0]  out_stride,
  output logic [sanorm_pkg::EXT_W-1:0]           out_count,
  output logic [sanorm_pkg::STAT_W-1:0]          status,
  output logic                                   last_of_run
);
  import sanorm_pkg::*;

  logic [RANK_W-1:0] tensor_rank;
  logic              cfg_write;

  // The access phase of an APB write commits the register; the word index
  // is paddr[2] and the byte offset bits are ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tensor_rank <= RANK_RESET;
    end else if (cfg_write && (paddr[2] == CFG_RANK)) begin
      tensor_rank <= pwdata[RANK_W-1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_RANK) ? APB_DW'(tensor_rank) : '0;

  sanorm_core u_core (
    .clk          (clk),
    .rst          (rst),
    .tensor_rank  (tensor_rank),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .axis_index   (axis_index),
    .start_pos    (start_pos),
    .end_pos      (end_pos),
    .stride       (stride),
    .extent_value (extent_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_axis     (out_axis),
    .out_start    (out_start),
    .out_stride   (out_stride),
    .out_count    (out_count),
    .status       (status),
    .last_of_run  (last_of_run)
  );

endmodule

// File: src/sanorm_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on sanorm_pkg for widths and the request/response structs.
module sanorm_div (
  input  logic                  clk,
  input  logic                  rst,
  input  sanorm_pkg::div_req_t  req,
  output sanorm_pkg::div_rsp_t  rsp
);
  import sanorm_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] q_sh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;

  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] trial;
  logic             ge;
  logic [DEN_W-1:0] rem_next;

  // The partial remainder stays below the divisor, so the shifted value is
  // below twice the divisor and one subtract settles each bit.
  assign shifted  = {rem, q_sh[NUM_W-1]};
  assign trial    = {1'b0, shifted} - {2'b00, den_q};
  assign ge       = !trial[DEN_W+1];
  assign rem_next = ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        rem   <= '0;
        q_sh  <= req.num;
        den_q <= req.den;
        cnt   <= CNT_W'(NUM_W);
        busy  <= 1'b1;
      end else if (busy) begin
        rem  <= rem_next;
        q_sh <= {q_sh[NUM_W-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = q_sh;

endmodule

// File: src/sanorm_core.sv
// Sequencer of the slice axis normalizer: extent store, axis marks, bound
// arithmetic, the walk over unnamed axes and the output register.
// Depends on sanorm_pkg and instantiates sanorm_div.
module sanorm_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [sanorm_pkg::RANK_W-1:0]          tensor_rank,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [sanorm_pkg::OP_W-1:0]            operation,
  input  logic signed [sanorm_pkg::AXIN_W-1:0]   axis_index,
  input  logic signed [sanorm_pkg::COORD_W-1:0]  start_pos,
  input  logic signed [sanorm_pkg::COORD_W-1:0]  end_pos,
  input  logic signed [sanorm_pkg::COORD_W-1:0]  stride,
  input  logic [sanorm_pkg::EXT_W-1:0]           extent_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [sanorm_pkg::AXIS_W-1:0]          out_axis,
  output logic [sanorm_pkg::EXT_W-1:0]           out_start,
  output logic signed [sanorm_pkg::COORD_W-1:0]  out_stride,
  output logic [sanorm_pkg::EXT_W-1:0]           out_count,
  output logic [sanorm_pkg::STAT_W-1:0]          status,
  output logic                                   last_of_run
);
  import sanorm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_WRAP_S, S_WRAP_E, S_CLAMP_S, S_CLAMP_E,
    S_DIFF, S_NUM, S_DIV, S_EMIT, S_W_ADDR, S_W_EMIT
  } state_t;

  state_t state;

  // Axis normalization on the incoming beat.
  logic [RANK_W-1:0]        rank_eff;
  logic signed [AXIN_W:0]   ax_wide;
  logic signed [AXIN_W:0]   ax_norm;
  logic                     ax_ok;
  logic [AXIS_W-1:0]        ax_sel;

  assign rank_eff = (tensor_rank > RANK_W'(MAX_RANK)) ? RANK_W'(MAX_RANK) : tensor_rank;
  assign ax_wide  = {axis_index[AXIN_W-1], axis_index};
  assign ax_norm  = ax_wide[AXIN_W] ? ax_wide + $signed({1'b0, rank_eff}) : ax_wide;
  assign ax_ok    = !ax_norm[AXIN_W] && (ax_norm[AXIN_W-1:0] < rank_eff);
  assign ax_sel   = ax_norm[AXIS_W-1:0];

  assign in_ready = (state == S_IDLE);

  // Captured request and working registers.
  logic [AXIS_W-1:0]        cap_axis;
  logic [COORD_W-1:0]       cap_start;
  logic [COORD_W-1:0]       cap_end;
  logic [COORD_W-1:0]       cap_step;
  logic                     neg;
  logic [DEN_W-1:0]         mag;
  logic signed [WIDE_W-1:0] s_val;
  logic signed [WIDE_W-1:0] e_val;
  logic signed [WIDE_W-1:0] hi_b;
  logic signed [WIDE_W-1:0] diff;
  logic [MAX_RANK-1:0]      marked;
  logic [RANK_W-1:0]        widx;

  logic [AXIS_W-1:0]        res_axis;
  logic [EXT_W-1:0]         res_start;
  logic [COORD_W-1:0]       res_stride;
  logic [EXT_W-1:0]         res_count;
  logic [STAT_W-1:0]        res_status;

  // Extent store: written on a load beat, read through a register.
  logic [EXT_W-1:0]         ext_mem [MAX_RANK];
  logic [EXT_W-1:0]         ext_rd;
  logic [AXIS_W-1:0]        rd_addr;
  logic                     ext_we;

  assign ext_we  = in_valid && in_ready && (operation == OP_LOAD) && ax_ok;
  assign rd_addr = (state == S_W_ADDR || state == S_W_EMIT) ? widx[AXIS_W-1:0] : cap_axis;

  always_ff @(posedge clk) begin
    if (ext_we) begin
      ext_mem[ax_sel] <= extent_value;
    end
    ext_rd <= ext_mem[rd_addr];
  end

  // Bound arithmetic operands.
  logic signed [WIDE_W-1:0] start_x;
  logic signed [WIDE_W-1:0] end_x;
  logic signed [WIDE_W-1:0] dim_x;
  logic signed [WIDE_W-1:0] lo_e;
  logic signed [WIDE_W-1:0] s_hi;
  logic signed [WIDE_W-1:0] e_hi;
  logic                     zero_cnt;

  assign start_x  = {{2{cap_start[COORD_W-1]}}, cap_start};
  assign end_x    = {{2{cap_end[COORD_W-1]}}, cap_end};
  assign dim_x    = {3'b000, ext_rd};
  assign lo_e     = {WIDE_W{neg}};
  assign s_hi     = (s_val > hi_b) ? hi_b : s_val;
  assign e_hi     = (e_val > hi_b) ? hi_b : e_val;
  assign zero_cnt = diff[WIDE_W-1] || (diff == '0) || (neg && (ext_rd == '0));

  // Walk support: is any unmarked axis left above the current one?
  logic [MAX_RANK-1:0] pend;
  logic                walk_last;
  logic                out_free;
  logic                out_load;

  always_comb begin
    for (int k = 0; k < MAX_RANK; k++) begin
      pend[k] = !marked[k] && (RANK_W'(k) < rank_eff) && (RANK_W'(k) > widx);
    end
  end
  assign walk_last = (pend == '0);
  assign out_free  = !out_valid || out_ready;
  // The output register takes a new beat in either emit state once it is free.
  assign out_load  = ((state == S_EMIT) || (state == S_W_EMIT)) && out_free;

  // Divider hookup.
  logic             div_go;
  logic [NUM_W-1:0] div_num;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign div_req.go  = div_go;
  assign div_req.num = div_num;
  assign div_req.den = mag;

  sanorm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      marked    <= '0;
      div_go    <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cap_axis   <= ax_sel;
            cap_start  <= start_pos;
            cap_end    <= end_pos;
            cap_step   <= stride;
            neg        <= stride[COORD_W-1];
            res_axis   <= ax_ok ? ax_sel : '0;
            res_start  <= '0;
            res_stride <= '0;
            res_count  <= '0;
            case (operation)
              OP_LOAD: begin
                res_status <= ax_ok ? ST_OK : ST_BAD_AXIS;
                state      <= S_EMIT;
              end
              OP_SLICE: begin
                if (!ax_ok) begin
                  res_status <= ST_BAD_AXIS;
                  state      <= S_EMIT;
                end else if (stride == '0) begin
                  res_status <= ST_ZERO_STEP;
                  state      <= S_EMIT;
                end else begin
                  res_status     <= ST_OK;
                  res_stride     <= stride;
                  marked[ax_sel] <= 1'b1;
                  state          <= S_READ;
                end
              end
              OP_FINISH: begin
                widx  <= '0;
                state <= S_W_ADDR;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_READ: begin
          mag   <= (cap_step ^ {COORD_W{neg}}) + COORD_W'(neg);
          state <= S_WRAP_S;
        end
        S_WRAP_S: begin
          s_val <= cap_start[COORD_W-1] ? start_x + dim_x : start_x;
          hi_b  <= dim_x - WIDE_W'(neg);
          state <= S_WRAP_E;
        end
        S_WRAP_E: begin
          e_val <= cap_end[COORD_W-1] ? end_x + dim_x : end_x;
          state <= S_CLAMP_S;
        end
        S_CLAMP_S: begin
          s_val <= s_hi[WIDE_W-1] ? '0 : s_hi;
          state <= S_CLAMP_E;
        end
        S_CLAMP_E: begin
          e_val <= (e_hi < lo_e) ? lo_e : e_hi;
          state <= S_DIFF;
        end
        S_DIFF: begin
          diff      <= neg ? s_val - e_val : e_val - s_val;
          res_start <= s_val[EXT_W-1:0];
          state     <= S_NUM;
        end
        S_NUM: begin
          if (zero_cnt) begin
            res_count <= '0;
            state     <= S_EMIT;
          end else begin
            div_num <= diff[NUM_W-1:0] + {1'b0, mag} - NUM_W'(1);
            div_go  <= 1'b1;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_count <= div_rsp.quo[EXT_W-1:0];
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_axis    <= res_axis;
            out_start   <= res_start;
            out_stride  <= res_stride;
            out_count   <= res_count;
            status      <= res_status;
            last_of_run <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_W_ADDR: begin
          if (widx >= rank_eff) begin
            marked <= '0;
            state  <= S_IDLE;
          end else if (marked[widx[AXIS_W-1:0]]) begin
            widx <= widx + 1'b1;
          end else begin
            state <= S_W_EMIT;
          end
        end
        S_W_EMIT: begin
          if (out_free) begin
            out_axis    <= widx[AXIS_W-1:0];
            out_start   <= '0;
            out_stride  <= COORD_W'(1);
            out_count   <= ext_rd;
            status      <= ST_OK;
            last_of_run <= walk_last;
            widx        <= widx + 1'b1;
            state       <= S_W_ADDR;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
